>>> rtl/core/sapc_pkg.sv
// Shared types, codes and helpers for the sensor alarm with passcode clear.
// No dependencies; imported by sensor_alarm_with_passcode_clear.
package sapc_pkg;

    // Default passcode length in digits
    localparam int unsigned CODE_DIGITS_DEF = 4;

    // Field widths
    localparam int unsigned ADC_W   = 12;
    localparam int unsigned AXIS_W  = 13;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned CODE_W  = 14;
    localparam int unsigned CFG_W   = 14;
    localparam int unsigned IDX_W   = 2;

    // Packed stream widths
    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 8;

    // Saturation value of the gathered code
    localparam logic [CODE_W-1:0] CODE_MAX = '1;

    // Register reset values
    localparam logic [ADC_W-1:0]  LOW_LIMIT_RST   = 12'd0;
    localparam logic [ADC_W-1:0]  HIGH_LIMIT_RST  = 12'd4095;
    localparam logic [CODE_W-1:0] SECRET_CODE_RST = 14'd0;
    localparam logic [ADC_W-1:0]  MOVE_DELTA_RST  = 12'd10;

    typedef enum logic [1:0] {
        FUNC_ADC   = 2'd0,
        FUNC_ACCEL = 2'd1,
        FUNC_KEY   = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        CAUSE_NONE = 2'd0,
        CAUSE_HIGH = 2'd1,
        CAUSE_LOW  = 2'd2,
        CAUSE_MOVE = 2'd3
    } cause_t;

    typedef enum logic [1:0] {
        RES_NONE   = 2'd0,
        RES_ACCEPT = 2'd1,
        RES_REJECT = 2'd2
    } code_res_t;

    typedef enum logic [IDX_W-1:0] {
        REG_LOW_LIMIT   = 2'd0,
        REG_HIGH_LIMIT  = 2'd1,
        REG_SECRET_CODE = 2'd2,
        REG_MOVE_DELTA  = 2'd3
    } cfg_idx_t;

    // Magnitude of a signed axis reading; the most negative value maps to 4096
    function automatic logic [AXIS_W-1:0] axis_abs(input logic signed [AXIS_W-1:0] v);
        logic [AXIS_W-1:0] neg;
        neg = AXIS_W'(-v);
        return v[AXIS_W-1] ? neg : AXIS_W'(v);
    endfunction

    // True when the magnitude of an axis moved by at least delta
    function automatic logic axis_moved(
        input logic signed [AXIS_W-1:0] prev,
        input logic signed [AXIS_W-1:0] cur,
        input logic [ADC_W-1:0]         delta
    );
        logic signed [AXIS_W:0] diff;
        logic        [AXIS_W:0] mag;
        diff = $signed({1'b0, axis_abs(prev)}) - $signed({1'b0, axis_abs(cur)});
        mag  = diff[AXIS_W] ? (AXIS_W+1)'(-diff) : (AXIS_W+1)'(diff);
        return mag >= {2'b00, delta};
    endfunction

    // Append one decimal digit to the code, saturating at the code width
    function automatic logic [CODE_W-1:0] code_append(
        input logic [CODE_W-1:0]  code,
        input logic [DIGIT_W-1:0] digit
    );
        logic [CODE_W+3:0] wide;
        wide = {1'b0, code, 3'b000} + {3'b000, code, 1'b0} + {(CODE_W)'(0), digit};
        return (wide > {4'b0000, CODE_MAX}) ? CODE_MAX : wide[CODE_W-1:0];
    endfunction

endpackage

>>> rtl/core/sensor_alarm_with_passcode_clear.sv
// Top level of the sensor alarm with passcode clear: input register, alarm
// logic and result register. Depends on sapc_pkg.
//
// Usage:
//   Requests arrive on the s_axis group: tuser carries the kind (temperature
//   sample, accelerometer sample, key digit), tdata the sample and digit
//   fields. Every request yields exactly one result on the m_axis group,
//   showing the alarm state after that request plus the outcome of a finished
//   code attempt.
//   An accepted request is held in the input register, then moves into the
//   result register, where its result is valid; while the receiver keeps
//   up, one request is taken every cycle. The alarm state updates when a
//   request moves from the input register into the result register, so a
//   following request always sees the state left by the one before it.
//   When the receiver stalls, the result register holds and the input
//   register fills; s_axis_tready drops only when both are occupied.
//   Reset clears the alarm, the code entry, the axis baseline and loads the
//   configuration defaults (low 0, high 4095, code 0, delta 10).
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
module sensor_alarm_with_passcode_clear #(
    parameter int unsigned CODE_DIGITS = sapc_pkg::CODE_DIGITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [sapc_pkg::IDX_W-1:0]      cfg_index,
    input  logic [sapc_pkg::CFG_W-1:0]      cfg_data,
    // Request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: adc_sample[11:0], accel_x[24:12], accel_y[37:25], accel_z[50:38],
    //        key_digit[54:51], zero pad[55]
    input  logic [sapc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: func[1:0]
    input  logic [sapc_pkg::IN_USER_W-1:0]  s_axis_tuser,
    // Result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: alarm_active[0], alarm_cause[2:1], digits_entered[4:3],
    //        code_result[6:5], zero pad[7]
    output logic [sapc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import sapc_pkg::*;

    localparam int unsigned CNT_W = (CODE_DIGITS > 4) ? $clog2(CODE_DIGITS) : 2;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CODE_DIGITS - 1);

    // Configuration registers
    logic [ADC_W-1:0]  low_limit_reg;
    logic [ADC_W-1:0]  high_limit_reg;
    logic [CODE_W-1:0] secret_code_reg;
    logic [ADC_W-1:0]  move_delta_reg;

    // Input register
    logic                     in_valid_reg;
    logic [1:0]               in_func_reg;
    logic [ADC_W-1:0]         in_adc_reg;
    logic signed [AXIS_W-1:0] in_x_reg;
    logic signed [AXIS_W-1:0] in_y_reg;
    logic signed [AXIS_W-1:0] in_z_reg;
    logic [DIGIT_W-1:0]       in_digit_reg;

    // Alarm state
    cause_t                   cause_reg, cause_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CODE_W-1:0]        code_reg, code_next;
    logic signed [AXIS_W-1:0] prev_x_reg, prev_x_next;
    logic signed [AXIS_W-1:0] prev_y_reg, prev_y_next;
    logic signed [AXIS_W-1:0] prev_z_reg, prev_z_next;
    logic                     base_valid_reg, base_valid_next;

    // Result register
    logic                     out_valid_reg;
    cause_t                   out_cause_reg;
    logic [1:0]               out_digits_reg;
    code_res_t                out_result_reg;
    code_res_t                result_next;

    logic                     in_take;
    logic                     advance;
    logic                     active;
    logic                     moved;
    logic [CODE_W-1:0]        code_sum;

    // Move a request forward when the result register is free or being read
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_limit_reg   <= LOW_LIMIT_RST;
            high_limit_reg  <= HIGH_LIMIT_RST;
            secret_code_reg <= SECRET_CODE_RST;
            move_delta_reg  <= MOVE_DELTA_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_LOW_LIMIT:   low_limit_reg   <= cfg_data[ADC_W-1:0];
                REG_HIGH_LIMIT:  high_limit_reg  <= cfg_data[ADC_W-1:0];
                REG_SECRET_CODE: secret_code_reg <= cfg_data[CODE_W-1:0];
                REG_MOVE_DELTA:  move_delta_reg  <= cfg_data[ADC_W-1:0];
                default:         ;
            endcase
        end
    end

    // Hold the input request valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    // Capture the input request fields
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_func_reg  <= s_axis_tuser[1:0];
            in_adc_reg   <= s_axis_tdata[11:0];
            in_x_reg     <= s_axis_tdata[24:12];
            in_y_reg     <= s_axis_tdata[37:25];
            in_z_reg     <= s_axis_tdata[50:38];
            in_digit_reg <= s_axis_tdata[54:51];
        end
    end

    assign active   = (cause_reg != CAUSE_NONE);
    assign moved    = axis_moved(prev_x_reg, in_x_reg, move_delta_reg)
                   || axis_moved(prev_y_reg, in_y_reg, move_delta_reg)
                   || axis_moved(prev_z_reg, in_z_reg, move_delta_reg);
    assign code_sum = code_append(code_reg, in_digit_reg);

    // Next alarm state for the request in the input register
    always_comb
    begin
        cause_next      = cause_reg;
        count_next      = count_reg;
        code_next       = code_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        prev_z_next     = prev_z_reg;
        base_valid_next = base_valid_reg;
        result_next     = RES_NONE;
        case (in_func_reg)
            FUNC_ADC:
            begin
                if (!active)
                begin
                    if (in_adc_reg > high_limit_reg)
                        cause_next = CAUSE_HIGH;
                    else if (in_adc_reg < low_limit_reg)
                        cause_next = CAUSE_LOW;
                end
            end
            FUNC_ACCEL:
            begin
                if (!active)
                begin
                    if (base_valid_reg && moved)
                        cause_next = CAUSE_MOVE;
                    prev_x_next     = in_x_reg;
                    prev_y_next     = in_y_reg;
                    prev_z_next     = in_z_reg;
                    base_valid_next = 1'b1;
                end
            end
            FUNC_KEY:
            begin
                if (active)
                begin
                    if (count_reg == CNT_LAST)
                    begin
                        // Attempt complete: check and restart entry
                        if (code_sum == secret_code_reg)
                        begin
                            if (cause_reg == CAUSE_MOVE)
                                base_valid_next = 1'b0;
                            cause_next  = CAUSE_NONE;
                            result_next = RES_ACCEPT;
                        end
                        else
                        begin
                            result_next = RES_REJECT;
                        end
                        count_next = '0;
                        code_next  = '0;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        code_next  = code_sum;
                    end
                end
            end
            default: ;
        endcase
    end

    // Update the alarm state as a request advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cause_reg      <= CAUSE_NONE;
            count_reg      <= '0;
            code_reg       <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_z_reg     <= '0;
            base_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            cause_reg      <= cause_next;
            count_reg      <= count_next;
            code_reg       <= code_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            prev_z_reg     <= prev_z_next;
            base_valid_reg <= base_valid_next;
        end
    end

    // Hold the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Capture the result fields
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_cause_reg  <= cause_next;
            out_digits_reg <= count_next[1:0];
            out_result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_result_reg, out_digits_reg, out_cause_reg,
                            out_cause_reg != CAUSE_NONE};

    // Digits are only gathered while an alarm is latched
    a_idle_no_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (cause_reg == CAUSE_NONE) |-> (count_reg == '0 && code_reg == '0))
        else $error("code entry in progress without an alarm");

    // A latched cause only changes by being cleared
    a_first_cause: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(cause_reg) != CAUSE_NONE && cause_reg != $past(cause_reg))
        |-> (cause_reg == CAUSE_NONE))
        else $error("latched alarm cause overwritten");

    // An accepted code always leaves the alarm cleared
    a_accept_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_result_reg == RES_ACCEPT)
        |-> (out_cause_reg == CAUSE_NONE && out_digits_reg == 2'd0))
        else $error("accepted code left alarm latched");

    // State only moves when a request advances
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(cause_reg) && $stable(count_reg) && $stable(base_valid_reg)))
        else $error("alarm state changed without a request");

endmodule
